// ----- rtl/oai_pkg.sv -----
// Package for the ordered array block: operation and status codes, the
// command that the controller broadcasts to the cell chain, and fixed port widths.
// No dependencies.
package oai_pkg;

	localparam int OP_W = 3;
	localparam int POS_W = 7;
	localparam int PORT_DW = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      rd_en;
	} cmd_t;

endpackage

// ----- rtl/ordered_array_insert_remove_top.sv -----
// Top level of the ordered array with insert and remove: a row of shift
// cells, the controller, and the registered result stage. Uses oai_pkg,
// oai_ctrl and oai_cell.
//
// The block keeps up to CAPACITY words in order with a fill count and takes
// one item per clock cycle while its result is not stalled; the result is
// loaded into the output register when the item is accepted. Every cell of
// the chain loads its own word, its left or right neighbor's word or the new
// word at once, so insert and remove shift all later entries together.
// A new item is accepted whenever the output register is empty or its
// result is taken in the same cycle. Reset clears the fill count and the
// output valid flag; there is no clearing pass, and the block is ready right after reset.
module ordered_array_insert_remove_top #(
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [oai_pkg::OP_W-1:0]      operation,
	input  logic [oai_pkg::POS_W-1:0]     position,
	input  logic [oai_pkg::PORT_DW-1:0]   data_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [oai_pkg::PORT_DW-1:0]   data_out,
	output logic [oai_pkg::STATUS_W-1:0]  status,
	output logic [oai_pkg::COUNT_W-1:0]   count
);
	import oai_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
	localparam int XW = (DATA_WIDTH > PORT_DW) ? DATA_WIDTH : PORT_DW;

	logic                  accept;
	cmd_t                  cmd;
	logic [CMP_W-1:0]      cmd_pos;
	status_t               st;
	logic [CW-1:0]         count_next;
	logic [XW-1:0]         din_x;
	logic [DATA_WIDTH-1:0] din;
	logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_sel [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_word;
	logic [XW-1:0]         rd_x;

	logic                  out_valid_q;
	logic [PORT_DW-1:0]    data_out_q;
	logic [STATUS_W-1:0]   status_q;
	logic [COUNT_W-1:0]    count_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	assign din_x = XW'(data_in);
	assign din = din_x[DATA_WIDTH-1:0];

	oai_ctrl #(
		.CAPACITY(CAPACITY),
		.CW(CW),
		.CMP_W(CMP_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.operation(operation),
		.position(position),
		.cmd(cmd),
		.cmd_pos(cmd_pos),
		.status(st),
		.count_next(count_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end
		oai_cell #(
			.DW(DATA_WIDTH),
			.IDX_W(CMP_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.pos(cmd_pos),
			.din(din),
			.left(left_w),
			.right(right_w),
			.q(cell_q[i]),
			.sel(cell_sel[i])
		);
	end

	// At most one cell drives a nonzero word, so an OR gathers the read.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_sel[i];
		end
	end

	assign rd_x = XW'(rd_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q <= cmd.rd_en ? rd_x[PORT_DW-1:0] : '0;
			status_q   <= st;
			count_q    <= COUNT_W'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign data_out = data_out_q;
	assign status = status_q;
	assign count = count_q;

endmodule

// ----- rtl/oai_cell.sv -----
// One storage cell of the ordered array chain. It holds one entry, takes its left
// or right neighbor's word on insert or remove, and the new word on insert or write at its index. Uses oai_pkg.
module oai_cell #(
	parameter int DW = 32,
	parameter int IDX_W = 7,
	parameter int INDEX = 0
) (
	input  logic            clk,
	input  oai_pkg::cmd_t   cmd,
	input  logic [IDX_W-1:0] pos,
	input  logic [DW-1:0]   din,
	input  logic [DW-1:0]   left,
	input  logic [DW-1:0]   right,
	output logic [DW-1:0]   q,
	output logic [DW-1:0]   sel
);
	import oai_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DW-1:0] entry_q;
	logic [DW-1:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		case (cmd.kind)
			CMD_INSERT: begin
				if (MY_IDX > pos) begin
					entry_d = left;
				end else if (MY_IDX == pos) begin
					entry_d = din;
				end
			end
			CMD_REMOVE: begin
				if (MY_IDX >= pos) begin
					entry_d = right;
				end
			end
			CMD_WRITE: begin
				if (MY_IDX == pos) begin
					entry_d = din;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign q = entry_q;
	// Only the addressed cell puts its word on the read bus.
	assign sel = (MY_IDX == pos) ? entry_q : '0;

endmodule

// ----- rtl/oai_ctrl.sv -----
// Controller for the ordered array: holds the fill count, checks range and
// full conditions, and issues one command per item to the cells. Uses oai_pkg.
module oai_ctrl #(
	parameter int CAPACITY = 64,
	parameter int CW = 7,
	parameter int CMP_W = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [oai_pkg::OP_W-1:0] operation,
	input  logic [oai_pkg::POS_W-1:0] position,
	output oai_pkg::cmd_t          cmd,
	output logic [CMP_W-1:0]       cmd_pos,
	output oai_pkg::status_t       status,
	output logic [CW-1:0]          count_next
);
	import oai_pkg::*;

	localparam logic [CMP_W-1:0] CAP = CMP_W'(CAPACITY);

	logic [CW-1:0]    fill_q;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	cmd_t             cmd_raw;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(fill_q);

	always_comb begin
		cmd_raw    = '{kind: CMD_HOLD, rd_en: 1'b0};
		cmd_pos    = pos_x;
		status     = ST_OK;
		count_next = fill_q;
		case (op_t'(operation))
			OP_APPEND: begin
				cmd_pos = cnt_x;
				if (cnt_x >= CAP) begin
					status = ST_FULL;
				end else begin
					cmd_raw.kind = CMD_INSERT;
					count_next   = fill_q + CW'(1);
				end
			end
			OP_INSERT: begin
				if (pos_x > cnt_x) begin
					status = ST_RANGE;
				end else if (cnt_x >= CAP) begin
					status = ST_FULL;
				end else begin
					cmd_raw.kind = CMD_INSERT;
					count_next   = fill_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.kind  = CMD_REMOVE;
					cmd_raw.rd_en = 1'b1;
					count_next    = fill_q - CW'(1);
				end
			end
			OP_READ: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.rd_en = 1'b1;
				end
			end
			OP_WRITE: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.kind  = CMD_WRITE;
					cmd_raw.rd_en = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = fill_q;
			end
		endcase
	end

	// Cells only move on an accepted item.
	always_comb begin
		cmd = cmd_raw;
		if (!accept) begin
			cmd.kind = CMD_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= count_next;
		end
	end

endmodule

// ----- rtl/oai_chk.sv -----
// Port checker for the ordered array block and the bind that attaches it
// to ordered_array_insert_remove_top. Uses oai_pkg.
module oai_chk #(
	parameter int CAPACITY = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [oai_pkg::PORT_DW-1:0]   data_out,
	input logic [oai_pkg::STATUS_W-1:0]  status,
	input logic [oai_pkg::COUNT_W-1:0]   count
);
	import oai_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

	// An accepted item always leaves a result in the output register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// Failed operations return no data.
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_out == '0)
		else $error("error result carries data");

	// A full report means the array holds exactly its capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == CAP_CNT)
		else $error("full reported with wrong count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
		else $error("unknown status code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count))
		else $error("stalled result changed");

endmodule

bind ordered_array_insert_remove_top oai_chk #(.CAPACITY(CAPACITY)) u_oai_chk (.*);
